// ===== design/maxplus_adjacency_power_core_macros.svh =====
// assertion macros for the max-plus adjacency power block
// used by the port checker; no other dependencies
`ifndef MAXPLUS_ADJACENCY_POWER_CORE_MACROS_SVH
`define MAXPLUS_ADJACENCY_POWER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MAP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MAP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/map_pkg.sv =====
// shared types and constants for the max-plus adjacency power block
// no dependencies
package map_pkg;

  localparam int MAX_NODES  = 8;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int ADDR_W     = 2 * IDX_W + 1;
  localparam int MEM_DEPTH  = 2 * MAX_NODES * MAX_NODES;
  localparam int VAL_W      = 8;
  localparam int POW_W      = 8;
  localparam int DIM_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_POWER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_NODES = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_COMP_RD,
    S_COMP_WR,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } map_state_t;

  typedef struct packed {
    logic load_row;
    logic start;
    logic wr_init;
    logic rd_comp;
    logic k_step;
    logic wr_comp;
    logic ij_step;
    logic it_step;
    logic out_load;
    logic finish;
  } map_cmd_t;

  typedef struct packed {
    logic k_last;
    logic ij_last;
    logic it_zero;
    logic it_one;
  } map_status_t;

endpackage

// ===== design/map_ctrl.sv =====
// sequencer for the max-plus adjacency power block
// depends on map_pkg for state, command and status types
module map_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  last_row,
  input  logic                  out_ready,
  input  map_pkg::map_status_t  status,
  output logic                  in_ready,
  output map_pkg::map_cmd_t     cmd
);
  import map_pkg::*;

  map_state_t state;
  map_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_row = 1'b1;
          if (last_row) begin
            cmd.start  = 1'b1;
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.wr_init = 1'b1;
        cmd.ij_step = 1'b1;
        if (status.ij_last) begin
          state_next = status.it_zero ? S_OUT_RD : S_COMP_RD;
        end
      end
      S_COMP_RD: begin
        cmd.rd_comp = 1'b1;
        cmd.k_step  = 1'b1;
        if (status.k_last) begin
          state_next = S_COMP_WR;
        end
      end
      S_COMP_WR: begin
        cmd.wr_comp = 1'b1;
        cmd.ij_step = 1'b1;
        state_next  = S_COMP_RD;
        if (status.ij_last) begin
          cmd.it_step = 1'b1;
          if (status.it_one) begin
            state_next = S_OUT_RD;
          end
        end
      end
      S_OUT_RD: begin
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready) begin
          if (status.ij_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.ij_step = 1'b1;
            state_next  = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/map_datapath.sv =====
// datapath: config registers, row store, index counters, matrix memory,
// max-plus accumulator and output register; depends on map_pkg
module map_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  map_pkg::map_cmd_t               cmd,
  output map_pkg::map_status_t            status,
  input  logic                            cfg_valid,
  input  logic [map_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [map_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [map_pkg::MAX_NODES-1:0]   row_bits,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [map_pkg::IDX_W-1:0]       row_index,
  output logic [map_pkg::IDX_W-1:0]       col_index,
  output logic [map_pkg::VAL_W-1:0]       element_value,
  output logic                            last_element
);
  import map_pkg::*;

  logic [POW_W-1:0]     matrix_power;
  logic [DIM_W-1:0]     active_nodes;
  logic [MAX_NODES-1:0] rows [MAX_NODES];
  logic [CNT_W-1:0]     rows_loaded;
  logic [IDX_W-1:0]     i_cnt;
  logic [IDX_W-1:0]     j_cnt;
  logic [IDX_W-1:0]     k_cnt;
  logic [IDX_W-1:0]     k_d;
  logic [IDX_W-1:0]     n_m1;
  logic [POW_W-1:0]     it_rem;
  logic                 cur;
  logic                 vld_d;
  logic [VAL_W-1:0]     acc;
  logic [VAL_W-1:0]     mem [MEM_DEPTH];
  logic [VAL_W-1:0]     rdata;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  logic [VAL_W-1:0]     wdata;
  logic                 wr_en;
  logic                 row_ok;
  logic                 a_ik;
  logic                 a_ij;
  logic [VAL_W:0]       sum;
  logic [VAL_W-1:0]     sat;
  logic [VAL_W-1:0]     best_next;
  logic                 room;

  // matrix dimension minus one, clamped to the supported range
  always_comb begin
    if (active_nodes == '0) begin
      n_m1 = '0;
    end else if (active_nodes > DIM_W'(MAX_NODES)) begin
      n_m1 = IDX_W'(MAX_NODES - 1);
    end else begin
      n_m1 = IDX_W'(active_nodes - DIM_W'(1));
    end
  end

  always_comb begin
    status.k_last  = (k_cnt == n_m1);
    status.ij_last = (i_cnt == n_m1) && (j_cnt == n_m1);
    status.it_zero = (it_rem == '0);
    status.it_one  = (it_rem == POW_W'(1));
  end

  // rows not loaded for this matrix read as zero
  assign row_ok = (CNT_W'(i_cnt) < rows_loaded);
  assign a_ik   = row_ok & rows[i_cnt][k_d];
  assign a_ij   = row_ok & rows[i_cnt][j_cnt];
  assign room   = (rows_loaded < CNT_W'(MAX_NODES));

  always_comb begin
    sum       = {1'b0, rdata} + (VAL_W+1)'(a_ik);
    sat       = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
    best_next = (vld_d && (sat > acc)) ? sat : acc;
  end

  assign raddr = cmd.rd_comp ? {cur, k_cnt, j_cnt} : {cur, i_cnt, j_cnt};
  assign waddr = cmd.wr_init ? {cur, i_cnt, j_cnt} : {~cur, i_cnt, j_cnt};
  assign wdata = cmd.wr_init ? VAL_W'(a_ij) : best_next;
  assign wr_en = cmd.wr_init | cmd.wr_comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_power <= POW_W'(1);
      active_nodes <= DIM_W'(MAX_NODES);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MATRIX_POWER: matrix_power <= cfg_data[POW_W-1:0];
        CFG_ACTIVE_NODES: active_nodes <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
    end else if (cmd.finish) begin
      rows_loaded <= '0;
    end else if (cmd.load_row && room) begin
      rows_loaded <= rows_loaded + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row && room) begin
      rows[rows_loaded[IDX_W-1:0]] <= row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt  <= '0;
      j_cnt  <= '0;
      k_cnt  <= '0;
      it_rem <= '0;
      cur    <= 1'b0;
      vld_d  <= 1'b0;
      acc    <= '0;
    end else begin
      vld_d <= cmd.rd_comp;
      if (cmd.start) begin
        i_cnt  <= '0;
        j_cnt  <= '0;
        k_cnt  <= '0;
        cur    <= 1'b0;
        it_rem <= (matrix_power == '0) ? '0 : matrix_power - POW_W'(1);
      end
      if (cmd.ij_step) begin
        if (j_cnt == n_m1) begin
          j_cnt <= '0;
          i_cnt <= (i_cnt == n_m1) ? '0 : i_cnt + IDX_W'(1);
        end else begin
          j_cnt <= j_cnt + IDX_W'(1);
        end
      end
      if (cmd.k_step) begin
        k_cnt <= (k_cnt == n_m1) ? '0 : k_cnt + IDX_W'(1);
      end
      if (cmd.it_step) begin
        it_rem <= it_rem - POW_W'(1);
        cur    <= ~cur;
      end
      if (cmd.start || cmd.wr_comp) begin
        acc <= '0;
      end else if (vld_d) begin
        acc <= best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_d <= k_cnt;
  end

  // ping-pong matrix store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      row_index     <= i_cnt;
      col_index     <= j_cnt;
      element_value <= rdata;
      last_element  <= status.ij_last;
    end
  end

endmodule

// ===== design/maxplus_adjacency_power_core.sv =====
// top level of the max-plus adjacency power block
// depends on map_pkg, map_ctrl and map_datapath
//
// usage:
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 sets matrix_power, index 1 sets active_nodes; write only when idle
//   input channel takes one adjacency row word per cycle while idle; the word
//   with last_row set closes the matrix and starts the computation
//   output channel gives one word per matrix element in row-major order,
//   last_element marks the final one
// sequence (n = dimension, p = power):
//   loading a row: stored when taken, no result
//   after the last row: the n*n matrix is copied in, then p-1 max-plus
//   products (none for p of 0) run one term per cycle through the single
//   read port of the matrix memory, then each element is read and loaded out
//   a stalled receiver holds the output word; nothing advances until taken
//   in_ready stays low from the last row until the final element is taken
// reset: power 1, dimension 8, no rows loaded, output empty; the matrix memory
//   needs no clearing pass
module maxplus_adjacency_power_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [map_pkg::MAX_NODES-1:0]   row_bits,
  input  logic                            last_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [map_pkg::IDX_W-1:0]       row_index,
  output logic [map_pkg::IDX_W-1:0]       col_index,
  output logic [map_pkg::VAL_W-1:0]       element_value,
  output logic                            last_element,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [map_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [map_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import map_pkg::*;

  map_cmd_t    cmd;
  map_status_t status;

  assign cfg_ready = 1'b1;

  map_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_row  (last_row),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  map_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .row_bits      (row_bits),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .last_element  (last_element)
  );

endmodule

// ===== design/map_checker.sv =====
// port-level checker for the max-plus adjacency power block, bound to the top
// depends on map_pkg and maxplus_adjacency_power_core_macros.svh
`include "maxplus_adjacency_power_core_macros.svh"

module map_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [map_pkg::IDX_W-1:0]       row_index,
  input logic [map_pkg::IDX_W-1:0]       col_index,
  input logic [map_pkg::VAL_W-1:0]       element_value,
  input logic                            last_element
);

  // output word holds while stalled
  `MAP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(element_value) && $stable(row_index) && $stable(col_index), "output word changed while stalled")

  // no row taken while results are pending
  `MAP_ASSERT_IMP(a_no_overlap, in_ready, !out_valid, "input ready while output word pending")

  // after the final element the block is idle again
  `MAP_ASSERT_NXT(a_done_idle, out_valid && out_ready && last_element, in_ready && !out_valid, "block not idle after final element")

  // final element sits on the diagonal of a square matrix
  `MAP_ASSERT_IMP(a_last_diag, out_valid && last_element, row_index == col_index, "final element off the diagonal")

endmodule

bind maxplus_adjacency_power_core map_checker u_map_checker (.*);
